@@ hw/rtl/jkoe_pkg.sv @@
// Package for the keyed JSON object extractor: beat structs, codes and sizes.
// Used by the extractor top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package jkoe_pkg;

  // Sizes of the key window and the brace counter.
  localparam int MAX_KEY_CHARS = 14;
  localparam int MAX_NESTING   = 255;
  localparam int WINDOW_LEN    = MAX_KEY_CHARS + 1;
  localparam int SEEN_W        = $clog2(WINDOW_LEN + 1);
  localparam int DEPTH_W       = $clog2(MAX_NESTING + 1);
  localparam int KLEN_IDX_W    = $clog2(MAX_KEY_CHARS + 1);

  // Configuration register widths and the number of key characters each holds.
  localparam int KEY_FIRST_W     = 64;
  localparam int KEY_LAST_W      = 48;
  localparam int KEY_LEN_W       = 4;
  localparam int KEY_FIRST_CHARS = KEY_FIRST_W / 8;
  localparam int KEY_LAST_CHARS  = KEY_LAST_W / 8;
  localparam int CFG_DATA_W      = KEY_FIRST_W;
  localparam int CFG_IDX_W       = 2;
  localparam int LEN_EXT_W       = (KLEN_IDX_W > KEY_LEN_W) ? KLEN_IDX_W : KEY_LEN_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 2'd2;

  // Characters the scanner reacts to.
  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] OPEN_CH   = 8'h7B;
  localparam logic [7:0] CLOSE_CH  = 8'h7D;
  localparam logic [7:0] BSLASH_CH = 8'h5C;

  typedef enum logic [1:0] {
    PH_SEEK_KEY   = 2'd0,
    PH_SEEK_BRACE = 2'd1,
    PH_OBJECT     = 2'd2,
    PH_DONE       = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_CLOSE      = 2'd1,
    KIND_NOT_FOUND  = 2'd2,
    KIND_INCOMPLETE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_out;
    kind_e      kind;
  } out_beat_t;

endpackage

@@ hw/rtl/json_keyed_object_extractor_unit.sv @@
// Top level of the keyed JSON object extractor: key search, brace tracking, output stage.
// Depends on jkoe_pkg for beat structs, codes and sizes.
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_stall_o    in_beat_i  (char_in, end_of_message)
//   out       source     out_valid_o / out_stall_i  out_beat_o (char_out, kind)
//   cfg       sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One byte per cycle while the output is not stalled: a beat sits in the input
// register, where the key window compare and the depth update run; its result, if any,
// then lands in the output register.
// A stalled output register holds the input register; the input stalls once that is full.
// Reset clears the message state; the key registers reset to zero.
`timescale 1ns / 1ps

module json_keyed_object_extractor_unit
  import jkoe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [KEY_FIRST_W-1:0] key_first_q;
  logic [KEY_LAST_W-1:0]  key_last_q;
  logic [KEY_LEN_W-1:0]   key_len_q;

  logic     in_valid_q;
  in_beat_t in_beat_q;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q, out_beat_d;

  phase_e             phase_q, phase_d;
  logic [7:0]         recent_q [WINDOW_LEN];
  logic [7:0]         recent_d [WINDOW_LEN];
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               in_str_q, in_str_d;
  logic               escape_q, escape_d;

  logic [7:0]            key_chars [MAX_KEY_CHARS];
  logic [MAX_KEY_CHARS:0] match_len;
  logic [LEN_EXT_W-1:0]  key_len_ext;
  logic [KLEN_IDX_W-1:0] key_len_cap;
  logic                  key_hit;
  logic                  advance;
  logic                  in_ready;

  // The input register moves on when the output register is free or being taken,
  // and takes a new beat when it is empty or its beat moves on.
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_ready    = !in_valid_q || advance;
  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q <= '0;
      key_last_q  <= '0;
      key_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_FIRST: key_first_q <= cfg_data_i;
        CFG_KEY_LAST:  key_last_q  <= cfg_data_i[KEY_LAST_W-1:0];
        CFG_KEY_LEN:   key_len_q   <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Key characters laid out one per entry; characters past the registers read as zero.
  for (genvar c = 0; c < MAX_KEY_CHARS; c++) begin : g_key
    if (c < KEY_FIRST_CHARS) begin : g_first
      assign key_chars[c] = key_first_q[8*c +: 8];
    end else if (c < KEY_FIRST_CHARS + KEY_LAST_CHARS) begin : g_last
      assign key_chars[c] = key_last_q[8*(c-KEY_FIRST_CHARS) +: 8];
    end else begin : g_zero
      assign key_chars[c] = 8'h00;
    end
  end

  // Clamp the key length to MAX_KEY_CHARS, one less than the window size.
  assign key_len_ext = LEN_EXT_W'(key_len_q);
  assign key_len_cap = (key_len_ext > LEN_EXT_W'(MAX_KEY_CHARS)) ?
                       KLEN_IDX_W'(MAX_KEY_CHARS) : key_len_ext[KLEN_IDX_W-1:0];

  // Window compare for every possible key length. The newest byte sits in entry 0,
  // so entry j holds key character n-1-j and entry n the opening quote.
  always_comb begin
    for (int n = 0; n <= MAX_KEY_CHARS; n++) begin
      match_len[n] = (recent_q[n] == QUOTE_CH) && (seen_q >= SEEN_W'(n + 1));
      for (int j = 0; j < n; j++) begin
        if (recent_q[j] != key_chars[n-1-j]) begin
          match_len[n] = 1'b0;
        end
      end
    end
  end

  // The closing quote is the byte now in the input register.
  assign key_hit = match_len[key_len_cap] && (in_beat_q.char_in == QUOTE_CH);

  // Next message state and the result beat for the byte in the input register.
  always_comb begin
    logic       emit;
    logic [7:0] ch;
    emit       = 1'b0;
    ch         = in_beat_q.char_in;
    out_beat_d = '{char_out: ch, kind: KIND_BYTE};
    phase_d    = phase_q;
    recent_d   = recent_q;
    seen_d     = seen_q;
    depth_d    = depth_q;
    in_str_d   = in_str_q;
    escape_d   = escape_q;

    case (phase_q)
      PH_SEEK_KEY: begin
        if (key_hit) begin
          phase_d = PH_SEEK_BRACE;
        end else begin
          for (int k = WINDOW_LEN - 1; k > 0; k--) begin
            recent_d[k] = recent_q[k-1];
          end
          recent_d[0] = ch;
          if (seen_q < SEEN_W'(WINDOW_LEN)) begin
            seen_d = seen_q + SEEN_W'(1);
          end
        end
      end
      PH_SEEK_BRACE: begin
        if (ch == OPEN_CH) begin
          phase_d  = PH_OBJECT;
          depth_d  = DEPTH_W'(1);
          in_str_d = 1'b0;
          escape_d = 1'b0;
          emit     = 1'b1;
        end
      end
      PH_OBJECT: begin
        emit = 1'b1;
        if (escape_q) begin
          escape_d = 1'b0;
        end else if (in_str_q && ch == BSLASH_CH) begin
          escape_d = 1'b1;
        end else if (ch == QUOTE_CH) begin
          in_str_d = !in_str_q;
        end else if (!in_str_q) begin
          if (ch == OPEN_CH) begin
            if (depth_q >= DEPTH_W'(MAX_NESTING)) begin
              out_beat_d = '{char_out: 8'h00, kind: KIND_INCOMPLETE};
              phase_d    = PH_DONE;
            end else begin
              depth_d = depth_q + DEPTH_W'(1);
            end
          end else if (ch == CLOSE_CH) begin
            if (depth_q == DEPTH_W'(1) || depth_q == '0) begin
              depth_d         = '0;
              out_beat_d.kind = KIND_CLOSE;
              phase_d         = PH_DONE;
            end else begin
              depth_d = depth_q - DEPTH_W'(1);
            end
          end
        end
      end
      default: ;
    endcase

    // The last byte of a message reports a missing or cut-off object and clears state.
    if (in_beat_q.end_of_message) begin
      if (phase_d == PH_SEEK_KEY || phase_d == PH_SEEK_BRACE) begin
        emit       = 1'b1;
        out_beat_d = '{char_out: 8'h00, kind: KIND_NOT_FOUND};
      end else if (phase_d == PH_OBJECT) begin
        emit       = 1'b1;
        out_beat_d = '{char_out: 8'h00, kind: KIND_INCOMPLETE};
      end
      phase_d  = PH_SEEK_KEY;
      seen_d   = '0;
      depth_d  = '0;
      in_str_d = 1'b0;
      escape_d = 1'b0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        recent_d[k] = 8'h00;
      end
    end

    // Output register: load on a result, drain when taken.
    if (in_valid_q && advance) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_beat_q <= in_beat_i;
    end
  end

  // Message state, updated as each byte leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEEK_KEY;
      seen_q   <= '0;
      depth_q  <= '0;
      in_str_q <= 1'b0;
      escape_q <= 1'b0;
      for (int k = 0; k < WINDOW_LEN; k++) begin
        recent_q[k] <= 8'h00;
      end
    end else if (in_valid_q && advance) begin
      phase_q  <= phase_d;
      seen_q   <= seen_d;
      depth_q  <= depth_d;
      in_str_q <= in_str_d;
      escape_q <= escape_d;
      recent_q <= recent_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_beat_q <= out_beat_d;
    end
  end

endmodule

@@ hw/rtl/jkoe_unit_checker.sv @@
// Port checker for the keyed JSON object extractor, bound to its top level.
// Depends on jkoe_pkg for the beat structs and result codes.
`timescale 1ns / 1ps

module jkoe_unit_checker
  import jkoe_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  // Status results carry no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.kind == KIND_NOT_FOUND ||
                    out_beat_o.kind == KIND_INCOMPLETE) |-> out_beat_o.char_out == 8'h00)
    else $error("status result with nonzero byte");

  // The input only stalls behind a full, stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can move");

  // A result that appears after an empty cycle traces back to a byte taken at the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result beat without a matching input beat");

endmodule

bind json_keyed_object_extractor_unit jkoe_unit_checker u_jkoe_unit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

@@ bench/tb_json_keyed_object_extractor_unit.sv @@
// Self-checking testbench for the keyed JSON object extractor: a directed table, then
// random messages across several key settings, checked against a built-in predictor
// except pinned table rows. Depends on jkoe_pkg and json_keyed_object_extractor_unit.
`timescale 1ns / 1ps

module tb_json_keyed_object_extractor_unit;
  import jkoe_pkg::*;

  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 250;
  localparam int DEEP_SETTING      = 5;
  localparam int DRAIN_CYCLES      = 8;
  // The longest legal quiet stretch is a sender gap plus a receiver stall run;
  // this is many times that.
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int DIR_ROWS          = 27;

  // One row of the directed table; pinned rows carry the expected beat inline.
  typedef struct {
    logic [7:0] ch;
    logic       eom;
    bit         pinned;
    bit         pin_has;
    kind_e      pin_kind;
    logic [7:0] pin_char;
  } dir_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_beat    = '0;
  logic                  out_valid_o;
  logic                  out_stall  = 1'b0;
  out_beat_t             out_beat_o;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = CFG_KEY_FIRST;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Predictor copy of the key registers and of the message state.
  logic [KEY_FIRST_W-1:0] key_lo  = '0;
  logic [KEY_LAST_W-1:0]  key_hi  = '0;
  logic [KEY_LEN_W-1:0]   key_len = '0;
  logic [7:0]             recent_win [WINDOW_LEN];
  int unsigned            seen_cnt;
  phase_e                 scan_phase;
  int unsigned            nest_depth;
  bit                     in_text;
  bit                     escaped;

  out_beat_t   expected_q [$];
  logic [7:0]  msg_q [$];
  bit          mismatch_seen = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_tick    = 0;
  int unsigned stall_mode    = 0;

  // Quote, then key characters, quote; pinned rows are plain to read off.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00,     1'b1, 1'b1, 1'b1, KIND_NOT_FOUND,  8'h00},
    '{8'hFF,     1'b1, 1'b1, 1'b1, KIND_NOT_FOUND,  8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{8'h41,     1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{OPEN_CH,   1'b0, 1'b1, 1'b1, KIND_BYTE,       OPEN_CH},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{BSLASH_CH, 1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{CLOSE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{BSLASH_CH, 1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{OPEN_CH,   1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{CLOSE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{CLOSE_CH,  1'b0, 1'b1, 1'b1, KIND_CLOSE,      CLOSE_CH},
    '{8'hFF,     1'b0, 1'b1, 1'b0, KIND_BYTE,       8'h00},
    '{8'h00,     1'b1, 1'b1, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{8'h7A,     1'b1, 1'b1, 1'b1, KIND_NOT_FOUND,  8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{OPEN_CH,   1'b1, 1'b1, 1'b1, KIND_INCOMPLETE, 8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{QUOTE_CH,  1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{OPEN_CH,   1'b0, 1'b0, 1'b0, KIND_BYTE,       8'h00},
    '{8'h80,     1'b1, 1'b1, 1'b1, KIND_INCOMPLETE, 8'h00}
  };

  json_keyed_object_extractor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] key_byte(int unsigned c);
    if (c < KEY_FIRST_CHARS) return key_lo[8*c +: 8];
    if (c < KEY_FIRST_CHARS + KEY_LAST_CHARS) return key_hi[8*(c-KEY_FIRST_CHARS) +: 8];
    return 8'h00;
  endfunction

  // The searched pattern is the key with a quote on each side.
  function automatic int unsigned pattern_len();
    int unsigned n;
    n = 32'(key_len);
    if (n > MAX_KEY_CHARS) n = MAX_KEY_CHARS;
    return n + 2;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned p, int unsigned len);
    if (p == 0 || p + 1 == len) return QUOTE_CH;
    return key_byte(p - 1);
  endfunction

  // True when this byte completes the pattern over the recent-byte window.
  function automatic bit pattern_done(logic [7:0] ch);
    int unsigned len;
    len = pattern_len();
    if (seen_cnt + 1 < len) return 1'b0;
    if (pattern_byte(len - 1, len) != ch) return 1'b0;
    for (int unsigned k = 1; k < len; k++) begin
      if (pattern_byte(len - 1 - k, len) != recent_win[k-1]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    for (int k = 0; k < WINDOW_LEN; k++) recent_win[k] = 8'h00;
    seen_cnt   = 0;
    scan_phase = PH_SEEK_KEY;
    nest_depth = 0;
    in_text    = 1'b0;
    escaped    = 1'b0;
  endtask

  task automatic track_byte(input logic [7:0] ch, input logic eom,
                            output bit has, output out_beat_t r);
    has = 1'b0;
    r   = '{char_out: 8'h00, kind: KIND_BYTE};
    case (scan_phase)
      PH_SEEK_KEY: begin
        if (pattern_done(ch)) begin
          scan_phase = PH_SEEK_BRACE;
        end else begin
          for (int k = WINDOW_LEN - 1; k > 0; k--) recent_win[k] = recent_win[k-1];
          recent_win[0] = ch;
          if (seen_cnt < WINDOW_LEN) seen_cnt++;
        end
      end
      PH_SEEK_BRACE: begin
        if (ch == OPEN_CH) begin
          scan_phase = PH_OBJECT;
          nest_depth = 1;
          in_text    = 1'b0;
          escaped    = 1'b0;
          has        = 1'b1;
          r.char_out = ch;
        end
      end
      PH_OBJECT: begin
        has        = 1'b1;
        r.char_out = ch;
        if (escaped) begin
          escaped = 1'b0;
        end else if (in_text && ch == BSLASH_CH) begin
          escaped = 1'b1;
        end else if (ch == QUOTE_CH) begin
          in_text = !in_text;
        end else if (!in_text && ch == OPEN_CH) begin
          if (nest_depth >= MAX_NESTING) begin
            r          = '{char_out: 8'h00, kind: KIND_INCOMPLETE};
            scan_phase = PH_DONE;
          end else begin
            nest_depth++;
          end
        end else if (!in_text && ch == CLOSE_CH) begin
          if (nest_depth > 0) nest_depth--;
          if (nest_depth == 0) begin
            r.kind     = KIND_CLOSE;
            scan_phase = PH_DONE;
          end
        end
      end
      default: ;
    endcase
    // The final byte settles the message and clears the scan state.
    if (eom) begin
      if (scan_phase == PH_SEEK_KEY || scan_phase == PH_SEEK_BRACE) begin
        has = 1'b1;
        r   = '{char_out: 8'h00, kind: KIND_NOT_FOUND};
      end else if (scan_phase == PH_OBJECT) begin
        has = 1'b1;
        r   = '{char_out: 8'h00, kind: KIND_INCOMPLETE};
      end
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one beat from a falling edge and returns at the falling edge after
  // it was taken. Pinned rows queue their typed expectation instead of the
  // predicted one.
  task automatic send_beat(input logic [7:0] ch, input logic eom,
                           input bit pinned = 1'b0, input bit pin_has = 1'b0,
                           input out_beat_t pin_beat = '0);
    int unsigned gap;
    bit          has;
    out_beat_t   r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_beat  <= '{char_in: ch, end_of_message: eom};
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    track_byte(ch, eom, has, r);
    if (pinned) begin
      has = pin_has;
      r   = pin_beat;
    end
    if (has) begin
      expected_q.push_back(r);
    end
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Stops sending and waits for every expected beat, then for a further drain period.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes all three key registers on consecutive edges; block must be idle.
  task automatic write_key(input logic [KEY_FIRST_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                           input logic [CFG_DATA_W-1:0] len);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_KEY_FIRST;
    cfg_data <= lo;
    @(negedge clk_i);
    cfg_idx  <= CFG_KEY_LAST;
    cfg_data <= hi;
    @(negedge clk_i);
    cfg_idx  <= CFG_KEY_LEN;
    cfg_data <= len;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    key_lo  = lo;
    key_hi  = hi[KEY_LAST_W-1:0];
    key_len = len[KEY_LEN_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Message builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return QUOTE_CH;
      1:       return OPEN_CH;
      2:       return CLOSE_CH;
      3:       return BSLASH_CH;
      4:       return key_byte($urandom_range(0, MAX_KEY_CHARS - 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == QUOTE_CH || b == BSLASH_CH || b == OPEN_CH || b == CLOSE_CH) b = 8'h3A;
    return b;
  endfunction

  // Appends the quoted key; a spoiled one has a single byte flipped.
  task automatic push_key(input bit spoil);
    int unsigned len;
    int unsigned spot;
    logic [7:0]  b;
    len  = pattern_len();
    spot = $urandom_range(0, len - 1);
    for (int unsigned p = 0; p < len; p++) begin
      b = pattern_byte(p, len);
      if (spoil && p == spot) b = b ^ 8'h01;
      msg_q.push_back(b);
    end
  endtask

  // Appends a balanced object with nested braces, strings and escapes.
  task automatic push_object();
    int unsigned d;
    d = 1;
    msg_q.push_back(OPEN_CH);
    repeat ($urandom_range(0, 14)) begin
      case ($urandom_range(0, 5))
        0: if (d < 6) begin
          msg_q.push_back(OPEN_CH);
          d++;
        end
        1: if (d > 1) begin
          msg_q.push_back(CLOSE_CH);
          d--;
        end
        2: begin
          msg_q.push_back(QUOTE_CH);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 4))
              0: begin
                msg_q.push_back(BSLASH_CH);
                msg_q.push_back(noise_byte());
              end
              1:       msg_q.push_back(OPEN_CH);
              2:       msg_q.push_back(CLOSE_CH);
              default: msg_q.push_back(plain_byte());
            endcase
          end
          msg_q.push_back(QUOTE_CH);
        end
        3:       msg_q.push_back(BSLASH_CH);
        default: msg_q.push_back(plain_byte());
      endcase
    end
    while (d > 0) begin
      msg_q.push_back(CLOSE_CH);
      d--;
    end
  endtask

  // Mostly keyed messages with an object; the rest is noise, spoiled keys,
  // missing braces and objects cut short by the end of the message.
  task automatic compose_message();
    int unsigned pick;
    int unsigned obj_start;
    int unsigned cut;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    msg_q.delete();
    if (pick < 10) begin
      repeat ($urandom_range(1, 12)) msg_q.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 6)) msg_q.push_back(noise_byte());
      push_key(pick >= 90);
      if (pick < 22) begin
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(0, 255));
          msg_q.push_back((b == OPEN_CH) ? 8'h20 : b);
        end
      end else begin
        repeat ($urandom_range(0, 3)) msg_q.push_back(plain_byte());
        obj_start = msg_q.size();
        push_object();
        if (pick < 37) begin
          cut = $urandom_range(obj_start, msg_q.size() - 2);
          while (msg_q.size() > cut + 1) void'(msg_q.pop_back());
        end else begin
          repeat ($urandom_range(0, 3)) msg_q.push_back(noise_byte());
        end
      end
    end
  endtask

  // Keyed object nested to the limit, closed once, then pushed one past it.
  task automatic compose_deep_message();
    msg_q.delete();
    push_key(1'b0);
    repeat (MAX_NESTING) msg_q.push_back(OPEN_CH);
    msg_q.push_back(CLOSE_CH);
    msg_q.push_back(OPEN_CH);
    msg_q.push_back(OPEN_CH);
    repeat (3) msg_q.push_back(noise_byte());
  endtask

  task automatic play_message();
    foreach (msg_q[i]) send_beat(msg_q[i], i == msg_q.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: quiet, light random, periodic, heavy random.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 255) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      2:       out_stall <= (stall_tick % 5 != 0);
      default: out_stall <= ($urandom_range(0, 99) < 70);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: each taken beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: char_out=%02h kind=%0d",
               out_beat_o.char_out, out_beat_o.kind);
        mismatch_seen = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (out_beat_o.char_out !== want.char_out) begin
          $error("char_out: expected %02h, actual %02h", want.char_out, out_beat_o.char_out);
          mismatch_seen = 1'b1;
        end
        if (out_beat_o.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_beat_o.kind);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Watchdog: too long without a beat taken on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** json_keyed_object_extractor_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [KEY_FIRST_W-1:0] lo;
    logic [CFG_DATA_W-1:0]  hi;
    logic [CFG_DATA_W-1:0]  len;
    int unsigned            start_count;

    clear_scan();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table with the empty key left from reset.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_beat(dir_rows[i].ch, dir_rows[i].eom, dir_rows[i].pinned, dir_rows[i].pin_has,
                '{char_out: dir_rows[i].pin_char, kind: dir_rows[i].pin_kind});
    end

    // Random messages under a series of key settings.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      settle();
      lo  = {$urandom, $urandom};
      hi  = {$urandom, $urandom};
      len = CFG_DATA_W'($urandom_range(1, MAX_KEY_CHARS - 1));
      case (p)
        1: begin
          lo  = '1;
          hi  = '1;
          len = CFG_DATA_W'(MAX_KEY_CHARS);
        end
        2: len = CFG_DATA_W'(15);
        3: len = '0;
        4: begin
          lo = '0;
          hi = '0;
        end
        DEEP_SETTING: len = CFG_DATA_W'($urandom_range(0, 3));
        default: ;
      endcase
      write_key(lo, hi, len);
      start_count = items_sent;
      if (p == DEEP_SETTING) begin
        compose_deep_message();
        play_message();
      end
      while (items_sent - start_count < ITEMS_PER_SETTING) begin
        compose_message();
        play_message();
      end
    end

    settle();
    if (!mismatch_seen && expected_q.size() == 0) begin
      $display("** json_keyed_object_extractor_unit: PASSED **");
    end else begin
      $display("** json_keyed_object_extractor_unit: FAILED **");
    end
    $finish;
  end

endmodule
